// ===== rtl/m3inv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_pkg
// shared types, constants and sequencer encodings for the 3x3 inverter
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int DataW      = 32;
  localparam int FracBitsDf = 16;

  typedef logic signed [DataW-1:0] word_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PIVOT,
    ST_OP_START,
    ST_OP_WAIT,
    ST_EMIT
  } state_t;

  // shared unit operation
  typedef enum logic [1:0] {
    OP_MUL,
    OP_QUOT_NEG,
    OP_QUOT
  } op_t;

  typedef struct packed {
    logic  start;
    op_t   op;
    word_t a;
    word_t b;
  } alu_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t result;
  } alu_rsp_t;

  function automatic word_t sat32(input logic signed [DataW+32:0] v);
    word_t r;
    if (v > $signed({{33{1'b0}}, 1'b0, {(DataW-1){1'b1}}})) begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end else if (v < -$signed({{33{1'b0}}, 1'b1, {(DataW-1){1'b0}}})) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/m3inv_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_if
// valid/ready channels for matrix elements and inverse elements
// ----------------------------------------------------------------------------
interface m3inv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;
  modport source (output valid, output element, input ready);
  modport sink (input valid, input element, output ready);
endinterface

interface m3inv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inverse_element;
  logic               result_last;
  logic               degenerate;
  modport source (output valid, output inverse_element, output result_last,
                  output degenerate, input ready);
  modport sink (input valid, input inverse_element, input result_last,
                input degenerate, output ready);
endinterface

// ===== rtl/m3inv_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_alu
// shared multiply and restoring divide unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module m3inv_alu
  import m3inv_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDf
) (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int NumW = DataW + FRAC_BITS;
  localparam int CntW = $clog2(NumW + 1);

  logic                   busy;
  logic                   done;
  logic                   is_div;
  logic                   neg;
  logic                   negate_out;
  logic [NumW-1:0]        num;
  logic [DataW-1:0]       den;
  logic [DataW:0]         rem;
  logic [NumW-1:0]        quo;
  logic [CntW-1:0]        cnt;
  logic signed [2*DataW-1:0] prod;
  word_t                  result;

  logic [DataW:0]         amag;
  logic [DataW:0]         rem_sh;
  logic [DataW:0]         rem_sub;
  logic [2*DataW-1:0]     pmag;
  logic [2*DataW-1:0]     pshift;
  logic signed [DataW+32:0] wide;

  assign amag    = req.a[DataW-1] ? (DataW+1)'(-{req.a[DataW-1], req.a}) : {1'b0, req.a};
  assign rem_sh  = {rem[DataW-1:0], num[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_div <= (req.op != OP_MUL);
        negate_out <= (req.op == OP_QUOT_NEG);
        neg    <= req.a[DataW-1] ^ req.b[DataW-1];
        num    <= NumW'(amag) << FRAC_BITS;
        den    <= req.b[DataW-1] ? DataW'(-req.b) : DataW'(req.b);
        rem    <= '0;
        quo    <= '0;
        cnt    <= CntW'(NumW);
        prod   <= $signed(req.a) * $signed(req.b);
      end else if (busy) begin
        if (!is_div) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= sat32(wide);
        end else if (cnt != '0) begin
          cnt <= cnt - 1'b1;
          num <= {num[NumW-2:0], 1'b0};
          if (!rem_sub[DataW]) begin
            rem <= rem_sub;
            quo <= {quo[NumW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[NumW-2:0], 1'b0};
          end
        end else begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= sat32(wide);
        end
      end
    end
  end

  assign pmag   = prod[2*DataW-1] ? (2*DataW)'(-prod) : (2*DataW)'(prod);
  assign pshift = pmag >> FRAC_BITS;

  always_comb begin
    if (!is_div) begin
      wide = prod[2*DataW-1] ? -$signed({1'b0, pshift[DataW+31:0]})
                             : $signed({1'b0, pshift[DataW+31:0]});
    end else begin
      wide = (neg ^ negate_out) ? -$signed((DataW+33)'(quo))
                                : $signed((DataW+33)'(quo));
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

// ===== rtl/m3inv_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_seq
// load, pivot, elimination sequencer and result emission
// ----------------------------------------------------------------------------
module m3inv_seq
  import m3inv_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDf
) (
  input  logic     clk,
  input  logic     rst,
  m3inv_in_if.sink  in_ch,
  m3inv_out_if.source out_ch,
  output alu_req_t req,
  input  alu_rsp_t rsp
);

  // micro-op list: each op is a quotient or a multiply-add into a target
  typedef enum logic [1:0] { K_NONE, K_FACT, K_AXPY, K_DIAG } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       neg;      // quotient negated
    logic       tgt_e;    // target in identity side
    logic [3:0] na;       // operand a index
    logic [3:0] nb;       // operand b index (a matrix; identity side for a multiply with tgt_e)
    logic [3:0] tg;       // target index
    logic       zchk;     // check pivot b for zero first
  } uop_t;

  localparam word_t One = word_t'(1) <<< FRAC_BITS;

  function automatic uop_t uop(input logic [5:0] i);
    uop_t u;
    u = '{K_NONE, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0, 1'b0};
    case (i)
      // column 0, rows 1,2
      6'd0:  u = '{K_FACT, 1'b1, 1'b0, 4'd1, 4'd0, 4'd1, 1'b1};
      6'd1:  u = '{K_AXPY, 1'b0, 1'b0, 4'd4, 4'd3, 4'd4, 1'b0};
      6'd2:  u = '{K_AXPY, 1'b0, 1'b0, 4'd7, 4'd6, 4'd7, 1'b0};
      6'd3:  u = '{K_AXPY, 1'b0, 1'b1, 4'd1, 4'd0, 4'd1, 1'b0};
      6'd4:  u = '{K_AXPY, 1'b0, 1'b1, 4'd4, 4'd3, 4'd4, 1'b0};
      6'd5:  u = '{K_AXPY, 1'b0, 1'b1, 4'd7, 4'd6, 4'd7, 1'b0};
      6'd6:  u = '{K_FACT, 1'b1, 1'b0, 4'd2, 4'd0, 4'd2, 1'b0};
      6'd7:  u = '{K_AXPY, 1'b0, 1'b0, 4'd5, 4'd3, 4'd5, 1'b0};
      6'd8:  u = '{K_AXPY, 1'b0, 1'b0, 4'd8, 4'd6, 4'd8, 1'b0};
      6'd9:  u = '{K_AXPY, 1'b0, 1'b1, 4'd2, 4'd0, 4'd2, 1'b0};
      6'd10: u = '{K_AXPY, 1'b0, 1'b1, 4'd5, 4'd3, 4'd5, 1'b0};
      6'd11: u = '{K_AXPY, 1'b0, 1'b1, 4'd8, 4'd6, 4'd8, 1'b0};
      // second pivot (swap done before op 12)
      6'd12: u = '{K_FACT, 1'b1, 1'b0, 4'd5, 4'd4, 4'd5, 1'b1};
      6'd13: u = '{K_AXPY, 1'b0, 1'b0, 4'd8, 4'd7, 4'd8, 1'b0};
      6'd14: u = '{K_AXPY, 1'b0, 1'b1, 4'd2, 4'd1, 4'd2, 1'b0};
      6'd15: u = '{K_AXPY, 1'b0, 1'b1, 4'd5, 4'd4, 4'd5, 1'b0};
      6'd16: u = '{K_AXPY, 1'b0, 1'b1, 4'd8, 4'd7, 4'd8, 1'b0};
      // backward on column 2
      6'd17: u = '{K_FACT, 1'b1, 1'b0, 4'd6, 4'd8, 4'd6, 1'b1};
      6'd18: u = '{K_AXPY, 1'b0, 1'b1, 4'd0, 4'd2, 4'd0, 1'b0};
      6'd19: u = '{K_AXPY, 1'b0, 1'b1, 4'd3, 4'd5, 4'd3, 1'b0};
      6'd20: u = '{K_AXPY, 1'b0, 1'b1, 4'd6, 4'd8, 4'd6, 1'b0};
      6'd21: u = '{K_FACT, 1'b1, 1'b0, 4'd7, 4'd8, 4'd7, 1'b0};
      6'd22: u = '{K_AXPY, 1'b0, 1'b1, 4'd1, 4'd2, 4'd1, 1'b0};
      6'd23: u = '{K_AXPY, 1'b0, 1'b1, 4'd4, 4'd5, 4'd4, 1'b0};
      6'd24: u = '{K_AXPY, 1'b0, 1'b1, 4'd7, 4'd8, 4'd7, 1'b0};
      // backward on column 1
      6'd25: u = '{K_FACT, 1'b1, 1'b0, 4'd3, 4'd4, 4'd3, 1'b0};
      6'd26: u = '{K_AXPY, 1'b0, 1'b1, 4'd0, 4'd1, 4'd0, 1'b0};
      6'd27: u = '{K_AXPY, 1'b0, 1'b1, 4'd3, 4'd4, 4'd3, 1'b0};
      6'd28: u = '{K_AXPY, 1'b0, 1'b1, 4'd6, 4'd7, 4'd6, 1'b0};
      // diagonal scaling: e[i+j] / a[4j]
      6'd29: u = '{K_DIAG, 1'b0, 1'b1, 4'd0, 4'd0, 4'd0, 1'b0};
      6'd30: u = '{K_DIAG, 1'b0, 1'b1, 4'd3, 4'd0, 4'd3, 1'b0};
      6'd31: u = '{K_DIAG, 1'b0, 1'b1, 4'd6, 4'd0, 4'd6, 1'b0};
      6'd32: u = '{K_DIAG, 1'b0, 1'b1, 4'd1, 4'd4, 4'd1, 1'b0};
      6'd33: u = '{K_DIAG, 1'b0, 1'b1, 4'd4, 4'd4, 4'd4, 1'b0};
      6'd34: u = '{K_DIAG, 1'b0, 1'b1, 4'd7, 4'd4, 4'd7, 1'b0};
      6'd35: u = '{K_DIAG, 1'b0, 1'b1, 4'd2, 4'd8, 4'd2, 1'b0};
      6'd36: u = '{K_DIAG, 1'b0, 1'b1, 4'd5, 4'd8, 4'd5, 1'b0};
      6'd37: u = '{K_DIAG, 1'b0, 1'b1, 4'd8, 4'd8, 4'd8, 1'b0};
      default: u = '{K_NONE, 1'b0, 1'b0, 4'd0, 4'd0, 4'd0, 1'b0};
    endcase
    return u;
  endfunction

  state_t state;
  state_t state_next;

  word_t      a [9];
  word_t      e [9];
  word_t      f;
  logic [3:0] load_count;
  logic [5:0] pc;
  logic [1:0] pvstep;
  logic       degen;
  logic [3:0] emit_idx;

  uop_t  u;
  logic [32:0] m0, m1, m2;
  logic [1:0]  piv_row;
  logic [8:0]  id_mask;

  assign u = uop(pc);

  always_comb begin
    m0 = a[0][31] ? 33'(-{a[0][31], a[0]}) : {1'b0, a[0]};
    m1 = a[1][31] ? 33'(-{a[1][31], a[1]}) : {1'b0, a[1]};
    m2 = a[2][31] ? 33'(-{a[2][31], a[2]}) : {1'b0, a[2]};
  end

  // first-column pivot row and the swapped identity
  always_comb begin
    if (m1 > m0 && !(m2 > m1)) begin
      piv_row = 2'd1;
      id_mask = 9'h10A;
    end else if ((m2 > m1 && m1 > m0) || (m2 > m0 && !(m1 > m0))) begin
      piv_row = 2'd2;
      id_mask = 9'h054;
    end else begin
      piv_row = 2'd0;
      id_mask = 9'h111;
    end
  end

  logic [32:0] m4, m5;
  assign m4 = a[4][31] ? 33'(-{a[4][31], a[4]}) : {1'b0, a[4]};
  assign m5 = a[5][31] ? 33'(-{a[5][31], a[5]}) : {1'b0, a[5]};

  // alu request and mul-add stage
  word_t pivot_b;

  always_comb begin
    pivot_b = a[u.nb];
    req = '{1'b0, OP_MUL, '0, '0};
    if (state == ST_OP_START) begin
      req.start = 1'b1;
      case (u.kind)
        K_FACT:  req = '{1'b1, OP_QUOT_NEG, a[u.na], pivot_b};
        K_AXPY:  req = '{1'b1, OP_MUL, f, u.tgt_e ? e[u.nb] : a[u.nb]};
        K_DIAG:  req = '{1'b1, OP_QUOT, e[u.na], pivot_b};
        default: req = '{1'b0, OP_MUL, '0, '0};
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:     if (in_ch.valid && load_count == 4'd8) state_next = ST_PIVOT;
      ST_PIVOT:    state_next = ST_OP_START;
      ST_OP_START: begin
        if (pc == 6'd12 && pvstep == 2'd1) state_next = ST_OP_START;
        else if (u.kind == K_NONE) state_next = ST_EMIT;
        else if (u.zchk && pivot_b == '0) state_next = ST_EMIT;
        else state_next = ST_OP_WAIT;
      end
      ST_OP_WAIT:  if (rsp.done) state_next = ST_OP_START;
      ST_EMIT:     if (out_ch.ready && emit_idx == 4'd8) state_next = ST_LOAD;
      default:     state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  logic [32:0] sum;
  assign sum = {rsp.result[31], rsp.result} +
               (u.tgt_e ? {e[u.tg][31], e[u.tg]} : {a[u.tg][31], a[u.tg]});

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      pc         <= '0;
      pvstep     <= '0;
      degen      <= 1'b0;
      emit_idx   <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_ch.valid) begin
            a[load_count] <= in_ch.element;
            load_count    <= (load_count == 4'd8) ? 4'd0 : load_count + 4'd1;
          end
        end
        ST_PIVOT: begin
          // identity with first-column row swap
          for (int k = 0; k < 9; k++) e[k] <= id_mask[k] ? One : '0;
          pc <= '0;
          pvstep <= 2'd1;
          degen <= 1'b0;
          emit_idx <= '0;
          case (piv_row)
            2'd1: begin
              a[0] <= a[1]; a[1] <= a[0];
              a[3] <= a[4]; a[4] <= a[3];
              a[6] <= a[7]; a[7] <= a[6];
            end
            2'd2: begin
              a[0] <= a[2]; a[2] <= a[0];
              a[3] <= a[5]; a[5] <= a[3];
              a[6] <= a[8]; a[8] <= a[6];
            end
            default: ;
          endcase
        end
        ST_OP_START: begin
          if (pc == 6'd12 && pvstep == 2'd1) begin
            pvstep <= 2'd0;
            if (m5 > m4) begin
              for (int c = 0; c < 9; c += 3) begin
                a[c+1] <= a[c+2]; a[c+2] <= a[c+1];
                e[c+1] <= e[c+2]; e[c+2] <= e[c+1];
              end
            end
          end else if (u.kind != K_NONE && u.zchk && pivot_b == '0) begin
            degen <= 1'b1;
          end
        end
        ST_OP_WAIT: begin
          if (rsp.done) begin
            pc <= pc + 6'd1;
            case (u.kind)
              K_FACT: begin
                f <= rsp.result;
                a[u.tg] <= '0;
              end
              K_AXPY: begin
                if (u.tgt_e) e[u.tg] <= sat32((DataW+33)'($signed(sum)));
                else         a[u.tg] <= sat32((DataW+33)'($signed(sum)));
              end
              K_DIAG: e[u.tg] <= rsp.result;
              default: ;
            endcase
          end
        end
        ST_EMIT: begin
          if (out_ch.ready) emit_idx <= emit_idx + 4'd1;
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready            = (state == ST_LOAD);
  assign out_ch.valid           = (state == ST_EMIT);
  assign out_ch.inverse_element = degen ? '0 : e[emit_idx];
  assign out_ch.result_last     = (emit_idx == 4'd8);
  assign out_ch.degenerate      = degen;

endmodule

// ===== rtl/matrix3_inverse_pivoting.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_pivoting
// 3x3 fixed point inverse by Gauss-Jordan elimination with partial pivoting
// ----------------------------------------------------------------------------
// sequence: the nine elements are loaded, then come a pivot step, a second-swap step
// and up to 38 micro-ops on the shared unit (23 multiplies and 15 divides, fewer when
// a pivot is zero), a closing step and nine output transfers
// flow: the shared unit serves one micro-op at a time, and input is not ready while
// a matrix is in work
// reset: rst (sync) returns to loading with load count zero
module matrix3_inverse_pivoting
  import m3inv_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDf
) (
  input logic clk,
  input logic rst,
  m3inv_in_if.sink    in_ch,
  m3inv_out_if.source out_ch
);

  alu_req_t req;
  alu_rsp_t rsp;

  m3inv_seq #(.FRAC_BITS(FRAC_BITS)) u_seq (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .req(req), .rsp(rsp)
  );

  m3inv_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

endmodule

// ===== rtl/m3inv_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_chk
// port-level checks on the inverter
// ----------------------------------------------------------------------------
module m3inv_chk (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic out_degen,
  input logic [31:0] out_elem
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output both open");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_degen |-> out_elem == '0) else $error("degenerate value nonzero");

  a_degen_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid) |-> $stable(out_degen)) else $error("degen changed");

  a_last_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> in_ready) else $error("no return to load");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_elem) && $stable(out_last))
    else $error("output dropped while stalled");

endmodule

bind matrix3_inverse_pivoting m3inv_chk u_chk (
  .clk(clk), .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.result_last), .out_degen(out_ch.degenerate),
  .out_elem(out_ch.inverse_element)
);

// ===== tb/matrix3_inverse_pivoting_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_pivoting_test
// streams 3x3 matrices into the inverter and checks every inverse element,
// last marker and degenerate flag against a fixed point Gauss-Jordan model
// kept in the bench; runs directed singular cases, random matrices and
// phases of source idling, sink stalling and a long sink hold-off
// ----------------------------------------------------------------------------
module matrix3_inverse_pivoting_test;
  import m3inv_pkg::*;

  localparam int FRAC = FracBitsDf;
  localparam word_t ONE = word_t'(1) <<< FRAC;
  localparam word_t WMAX = 32'sh7fffffff;
  localparam word_t WMIN = 32'sh80000000;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;

  typedef struct {
    word_t value;
    logic  last;
    logic  degen;
  } inv_elem_t;

  logic clk;
  logic rst;

  m3inv_in_if  in_ch ();
  m3inv_out_if out_ch ();

  matrix3_inverse_pivoting dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  word_t     element_queue[$];
  inv_elem_t inverse_queue[$];
  word_t     load_buf[9];
  int        load_cnt;
  int        send_idle_pct;
  int        recv_stall_pct;
  logic      hold_active;
  event      hold_go;
  int        mismatches = 0;
  int        matrices_done = 0;
  int        degenerate_seen = 0;
  int        results_seen = 0;
  int        idle_cycles;
  logic      in_fire;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // fixed point helpers
  function automatic word_t sat_w(longint v);
    if (v > longint'(WMAX)) return WMAX;
    if (v < longint'(WMIN)) return WMIN;
    return word_t'(v);
  endfunction

  function automatic longint mag_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic word_t fmul(word_t a, word_t b);
    longint p;
    longint m;
    p = longint'(a) * longint'(b);
    m = mag_l(p) >> FRAC;
    return sat_w((p < 0) ? -m : m);
  endfunction

  function automatic word_t fadd(word_t a, word_t b);
    return sat_w(longint'(a) + longint'(b));
  endfunction

  function automatic longint fquot(word_t a, word_t b);
    longint n;
    longint q;
    n = mag_l(longint'(a)) << FRAC;
    q = n / mag_l(longint'(b));
    return ((a < 0) != (b < 0)) ? -q : q;
  endfunction

  function automatic void swap_rows(inout word_t m[9], input int r1, input int r2);
    word_t t;
    for (int c = 0; c < 9; c += 3) begin
      t = m[c + r1];
      m[c + r1] = m[c + r2];
      m[c + r2] = t;
    end
  endfunction

  function automatic void row_axpy(inout word_t m[9], input int dst, input int src,
                                   input word_t f);
    for (int c = 0; c < 9; c += 3) m[c + dst] = fadd(m[c + dst], fmul(f, m[c + src]));
  endfunction

  function automatic bit gauss_jordan(inout word_t a[9], output word_t e[9]);
    int    mi;
    word_t f;
    for (int i = 0; i < 9; i++) e[i] = 0;
    e[0] = ONE;
    e[4] = ONE;
    e[8] = ONE;
    mi = 0;
    if (mag_l(a[1]) > mag_l(a[mi])) mi = 1;
    if (mag_l(a[2]) > mag_l(a[mi])) mi = 2;
    if (mi != 0) begin
      swap_rows(e, 0, mi);
      swap_rows(a, 0, mi);
    end
    if (a[0] == 0) return 0;
    for (int j = 1; j < 3; j++) begin
      f = sat_w(-fquot(a[j], a[0]));
      a[j] = 0;
      a[3 + j] = fadd(a[3 + j], fmul(f, a[3]));
      a[6 + j] = fadd(a[6 + j], fmul(f, a[6]));
      row_axpy(e, j, 0, f);
    end
    if (mag_l(a[5]) > mag_l(a[4])) begin
      swap_rows(e, 1, 2);
      swap_rows(a, 1, 2);
    end
    if (a[4] == 0) return 0;
    f = sat_w(-fquot(a[5], a[4]));
    a[5] = 0;
    a[8] = fadd(a[8], fmul(f, a[7]));
    row_axpy(e, 2, 1, f);
    if (a[8] == 0) return 0;
    for (int j = 0; j < 2; j++) begin
      f = sat_w(-fquot(a[6 + j], a[8]));
      a[6 + j] = 0;
      row_axpy(e, j, 2, f);
    end
    f = sat_w(-fquot(a[3], a[4]));
    a[3] = 0;
    row_axpy(e, 0, 1, f);
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 9; i += 3) e[i + j] = sat_w(fquot(e[i + j], a[j * 4]));
    return 1;
  endfunction

  function automatic void predict_inverse(word_t m[9]);
    word_t     a[9];
    word_t     e[9];
    bit        ok;
    inv_elem_t r;
    a = m;
    ok = gauss_jordan(a, e);
    for (int k = 0; k < 9; k++) begin
      r.value = ok ? e[k] : word_t'(0);
      r.last  = (k == 8);
      r.degen = !ok;
      inverse_queue.push_back(r);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
    if (rst) begin
      load_cnt <= 0;
    end else if (in_ch.valid && in_ch.ready) begin
      load_buf[load_cnt] = in_ch.element;
      if (load_cnt == 8) begin
        predict_inverse(load_buf);
        load_cnt <= 0;
      end else begin
        load_cnt <= load_cnt + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (element_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.element <= element_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long sink hold-off
  initial begin
    hold_active = 1'b0;
    @(hold_go);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // sink side
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_active) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    inv_elem_t x;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (inverse_queue.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected transfer: element %0d last %b degenerate %b",
                   out_ch.inverse_element, out_ch.result_last, out_ch.degenerate);
      end else begin
        x = inverse_queue.pop_front();
        if (out_ch.result_last && out_ch.degenerate) degenerate_seen <= degenerate_seen + 1;
        if (out_ch.result_last) matrices_done <= matrices_done + 1;
        if (out_ch.inverse_element !== x.value || out_ch.result_last !== x.last ||
            out_ch.degenerate !== x.degen) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%b/%b got %0d/%b/%b", x.value, x.last, x.degen,
                     out_ch.inverse_element, out_ch.result_last, out_ch.degenerate);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout with %0d inverse elements outstanding", inverse_queue.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic queue_matrix(word_t m[9]);
    for (int i = 0; i < 9; i++) element_queue.push_back(m[i]);
  endtask

  function automatic word_t rand_elem(int kind);
    case (kind)
      0: return word_t'($urandom_range(0, 8 * 65536)) - 4 * 65536;
      1: return word_t'($urandom);
      default: return word_t'($urandom_range(0, 14)) - 7;
    endcase
  endfunction

  task automatic queue_random_matrix();
    word_t m[9];
    int    kind;
    int    sel;
    sel = $urandom_range(0, 9);
    kind = (sel < 6) ? 0 : (sel < 8) ? 1 : 2;
    for (int i = 0; i < 9; i++) begin
      m[i] = rand_elem(kind);
      if (kind == 0 && (i % 4) == 0) m[i] = m[i] + ($urandom_range(1) ? 6 * ONE : -6 * ONE);
    end
    if (sel == 9)
      for (int r = 0; r < 3; r++) m[6 + r] = m[r];
    if ($urandom_range(0, 7) == 0) m[1] = -m[0];
    queue_matrix(m);
  endtask

  task automatic drain();
    while (element_queue.size() > 0 || in_ch.valid || inverse_queue.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    word_t d[9];
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // column 0 all zero: first pivot zero, extremes elsewhere
    d = '{0, 0, 0, WMAX, WMIN, 1, -1, WMAX, WMIN};
    queue_matrix(d);
    // column 1 twice column 0 with a magnitude tie: second pivot zero
    d = '{ONE, -ONE, ONE, 2 * ONE, -2 * ONE, 2 * ONE, 3, 5, WMIN};
    queue_matrix(d);
    // column 2 is column 0 plus column 1: third pivot zero
    d = '{ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0};
    queue_matrix(d);
    -> hold_go;
    for (int i = 0; i < 4; i++) queue_random_matrix();
    drain();

    for (int ph = 1; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 86 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 86 : (ph == 3) ? 36 : 0;
      for (int i = 0; i < 4; i++) queue_random_matrix();
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d matrices (%0d degenerate), %0d inverse elements checked",
             matrices_done, degenerate_seen, results_seen);
    $display("phases: no idling, source idle, sink stall, both, plus a long sink hold-off");
    if (mismatches == 0 && inverse_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d elements missing", mismatches, inverse_queue.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
